### hdl/pip_pkg.sv
// shared types and constants for the point-in-polygon block
// used by the top level and the edge crossing unit; depends on nothing
`timescale 1ns / 1ps

package pip_pkg;

    // default polygon capacity
    localparam int MAX_VERTICES_DEF = 32;

    // coordinate and stored vertex widths
    localparam int COORD_W  = 16;
    localparam int VERTEX_W = 2 * COORD_W;

    // operation codes carried in s_axis_tuser
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // one stored vertex, x in the low half
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } vertex_t;

    // control tag that travels with an edge through the crossing pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } edge_tag_t;

    // per-edge verdict leaving the crossing pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } edge_res_t;

endpackage

### hdl/point_in_polygon_test.sv
// top level of the point-in-polygon block: vertex store, query walk and output register
// depends on pip_pkg, pip_ram and pip_edge
`timescale 1ns / 1ps

// Usage
// One input stream carries vertex writes and queries. s_axis_tuser holds the
// mode: start a new polygon with this vertex, append this vertex, or query
// this point; mode 3 is accepted and ignored. s_axis_tdata holds x (low half)
// and y (high half) as two's complement.
// A query walks the stored vertices, reading one ram entry per cycle, and
// streams each edge through a three-stage crossing pipeline. Queries
// against fewer than two vertices skip the walk. One query is in flight
// at a time; the input is ready only while no query is being worked on.
// The result transfer carries the parity bit in m_axis_tdata and the sticky
// overflow flag in m_axis_tuser. It is held in an output register; while the
// receiver stalls, vertex writes are still accepted, and a new query waits
// at its end until the register is free.
// Reset empties the polygon and clears the overflow flag; ram contents are
// not cleared and are never read before being written.

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pos_x [15:0], pos_y [31:16]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // inside_res [0], zero fill [7:1]
    output logic [0:0]  m_axis_tuser    // overflow_seen [0]
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    vertex_t          query_reg, query_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_first_reg, rd_first_next;
    logic             rd_last_reg, rd_last_next;
    logic             close_reg, close_next;
    vertex_t          first_reg, first_next;
    vertex_t          prev_reg, prev_next;
    logic             par_reg, par_next;
    logic             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_inside_reg, m_inside_next;
    logic             m_ovf_reg, m_ovf_next;

    logic             s_fire;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [VERTEX_W-1:0] ram_rdata;
    vertex_t          rd_vertex;
    edge_tag_t        edge_tag;
    vertex_t          edge_b;
    edge_res_t        edge_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign rd_vertex     = vertex_t'(ram_rdata);

    // vertex store
    pip_ram #(
        .WIDTH(VERTEX_W),
        .DEPTH(MAX_VERTICES)
    ) u_vertex_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // edge feed: consecutive vertices, then the closing edge back to vertex 0
    assign edge_tag.valid = (rd_valid_reg && !rd_first_reg) || close_reg;
    assign edge_tag.last  = close_reg;
    assign edge_b         = close_reg ? first_reg : rd_vertex;

    pip_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (edge_tag),
        .v0      (prev_reg),
        .v1      (edge_b),
        .pt      (query_reg),
        .res     (edge_res)
    );

    // control and write path
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        query_next    = query_reg;
        rd_idx_next   = rd_idx_reg;
        rd_valid_next = 1'b0;
        rd_first_next = 1'b0;
        rd_last_next  = 1'b0;
        close_next    = rd_valid_reg && rd_last_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        par_next      = par_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_inside_next = m_inside_reg;
        m_ovf_next    = m_ovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_re        = 1'b0;

        // result register drains on a transfer
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        // remember the previous and the first vertex read back
        if (rd_valid_reg) begin
            prev_next = rd_vertex;
            if (rd_first_reg) begin
                first_next = rd_vertex;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_axis_tuser)
                        MODE_START: begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CW'(1);
                            ovf_next   = 1'b0;
                        end
                        MODE_APPEND: begin
                            if (count_reg < CW'(MAX_VERTICES)) begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            query_next  = vertex_t'(s_axis_tdata);
                            par_next    = 1'b0;
                            rd_idx_next = '0;
                            if (count_reg < CW'(2)) begin
                                res_next   = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // issue one vertex read per cycle
                if (rd_idx_reg < count_reg) begin
                    ram_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_first_next = (rd_idx_reg == '0);
                    rd_last_next  = (rd_idx_reg == count_reg - CW'(1));
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end
                // accumulate crossing parity
                if (edge_res.valid) begin
                    par_next = par_reg ^ edge_res.hit;
                    if (edge_res.last) begin
                        res_next   = par_reg ^ edge_res.hit;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_inside_next = res_reg;
                    m_ovf_next    = ovf_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            close_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= rd_valid_next;
            close_reg    <= close_next;
            m_valid_reg  <= m_valid_next;
        end
        query_reg    <= query_next;
        rd_first_reg <= rd_first_next;
        rd_last_reg  <= rd_last_next;
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        par_reg      <= par_next;
        res_reg      <= res_next;
        m_inside_reg <= m_inside_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_inside_reg};
    assign m_axis_tuser  = m_ovf_reg;

endmodule

### hdl/pip_ram.sv
// generic simple dual-port ram with one write port and a registered read port
// no dependencies
`timescale 1ns / 1ps

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pip_edge.sv
// three-stage crossing test of one polygon edge against the query point
// depends on pip_pkg for vertex and tag types
`timescale 1ns / 1ps

module pip_edge
    import pip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  edge_tag_t in_tag,
    input  vertex_t   v0,
    input  vertex_t   v1,
    input  vertex_t   pt,
    output edge_res_t res
);

    logic signed [COORD_W-1:0] x0, y0, x1, y1, px, py;
    logic signed [COORD_W-1:0] ux, uy, ly;
    logic                      skip, fixed_hit, use_mul;

    edge_tag_t                 s1_tag_reg;
    logic signed [COORD_W:0]   s1_dx0_reg, s1_dy_reg, s1_dpy_reg, s1_dx_reg;
    logic                      s1_fixed_reg, s1_mul_reg;

    edge_tag_t                 s2_tag_reg;
    logic signed [2*COORD_W+1:0] s2_p0_reg, s2_p1_reg;
    logic                      s2_fixed_reg, s2_mul_reg, s2_neg_reg;

    logic [2*COORD_W+2:0]      sum;
    logic                      ge;
    edge_res_t                 res_reg;

    assign x0 = $signed(v0.x);
    assign y0 = $signed(v0.y);
    assign x1 = $signed(v1.x);
    assign y1 = $signed(v1.y);
    assign px = $signed(pt.x);
    assign py = $signed(pt.y);

    // classify the edge against the query row
    always_comb begin
        if (y1 > y0) begin
            ux = x1;
            uy = y1;
            ly = y0;
        end else begin
            ux = x0;
            uy = y0;
            ly = y1;
        end
        skip      = (y0 == y1) || (y0 > py && y1 > py) || (y0 < py && y1 < py);
        fixed_hit = !skip && (uy == py) && (ux >= px);
        use_mul   = !skip && (uy != py) && (ly != py);
    end

    // stage 1: differences and classification
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else begin
            s1_tag_reg <= in_tag;
        end
        s1_dx0_reg   <= {x0[COORD_W-1], x0} - {px[COORD_W-1], px};
        s1_dy_reg    <= {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
        s1_dpy_reg   <= {py[COORD_W-1], py} - {y0[COORD_W-1], y0};
        s1_dx_reg    <= {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
        s1_fixed_reg <= fixed_hit;
        s1_mul_reg   <= use_mul;
    end

    // stage 2: the two cross-product terms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg <= '0;
        end else begin
            s2_tag_reg <= s1_tag_reg;
        end
        s2_p0_reg    <= s1_dx0_reg * s1_dy_reg;
        s2_p1_reg    <= s1_dpy_reg * s1_dx_reg;
        s2_fixed_reg <= s1_fixed_reg;
        s2_mul_reg   <= s1_mul_reg;
        s2_neg_reg   <= s1_dy_reg[COORD_W];
    end

    // crossing lies at or right of the point when the signed sum agrees with dy
    always_comb begin
        sum = {s2_p0_reg[2*COORD_W+1], s2_p0_reg} + {s2_p1_reg[2*COORD_W+1], s2_p1_reg};
        if (s2_neg_reg) begin
            ge = sum[2*COORD_W+2] || (sum == '0);
        end else begin
            ge = !sum[2*COORD_W+2];
        end
    end

    // stage 3: verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
            res_reg.last  <= 1'b0;
        end else begin
            res_reg.valid <= s2_tag_reg.valid;
            res_reg.last  <= s2_tag_reg.last;
        end
        res_reg.hit <= s2_mul_reg ? ge : s2_fixed_reg;
    end

    assign res = res_reg;

endmodule
